FILE: design/btmx_pkg.sv
// Package for the binary trie max-XOR unit: default sizes, controller states and the
// command/status structs between controller and datapath.
// No dependencies.
package btmx_pkg;

  localparam int unsigned KeyBitsDef   = 31;
  localparam int unsigned NodeCountDef = 65536;
  localparam int unsigned FieldW       = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_ALLOC,
    ST_QRY_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic ins_walk;
    logic ins_alloc;
    logic qry_walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ins_to_alloc;
    logic ins_to_qry;
    logic alloc_to_qry;
    logic qry_end;
  } sts_t;

endpackage

FILE: design/btmx_ram.sv
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
module btmx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/btmx_ctrl.sv
// Controller for the binary trie max-XOR unit: sequences insert walk, node allocation,
// query walk and result strobe. Depends on btmx_pkg.
module btmx_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  btmx_pkg::sts_t sts_i,
  output btmx_pkg::cmd_t cmd_o,
  output logic           busy,
  output logic           done_o
);
  import btmx_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_INS_WALK;
      end
      ST_INS_WALK: begin
        if (sts_i.ins_to_alloc) state_d = ST_INS_ALLOC;
        else if (sts_i.ins_to_qry) state_d = ST_QRY_WALK;
      end
      ST_INS_ALLOC: begin
        if (sts_i.alloc_to_qry) state_d = ST_QRY_WALK;
      end
      ST_QRY_WALK: begin
        if (sts_i.qry_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_INS_WALK:  cmd_o.ins_walk  = 1'b1;
      ST_INS_ALLOC: cmd_o.ins_alloc = 1'b1;
      ST_QRY_WALK:  cmd_o.qry_walk  = 1'b1;
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        done_o       = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/btmx_dp.sv
// Datapath for the binary trie max-XOR unit: key, walk pointer, level counter, fill
// count, root links, running maximum and the node RAM. Depends on btmx_pkg, btmx_ram.
module btmx_dp #(
  parameter int unsigned KEY_BITS   = btmx_pkg::KeyBitsDef,
  parameter int unsigned NODE_COUNT = btmx_pkg::NodeCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  btmx_pkg::cmd_t              cmd_i,
  output btmx_pkg::sts_t              sts_o,
  input  logic [btmx_pkg::FieldW-1:0] key_value_i,
  input  logic                        start_of_set_i,
  output logic [btmx_pkg::FieldW-1:0] max_xor_o,
  output logic [btmx_pkg::FieldW-1:0] best_so_far_o,
  output logic                        store_full_o
);
  import btmx_pkg::*;

  localparam int unsigned IdxW   = $clog2(NODE_COUNT);
  localparam int unsigned CntW   = $clog2(NODE_COUNT + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned RW     = $clog2(KEY_BITS + 1);
  localparam int unsigned LvlW   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned WordW  = 2 * IdxW;

  logic [KEY_BITS-1:0] key_q;
  logic [IdxW-1:0]     pos_q;
  logic [RW-1:0]       r_q;
  logic [KEY_BITS-1:0] ans_q;
  logic [KEY_BITS-1:0] best_q;
  logic                full_q;
  logic [CntW-1:0]     next_free_q;
  logic [IdxW-1:0]     root_zero_q;
  logic [IdxW-1:0]     root_one_q;

  logic [LvlW-1:0]     lvl;
  logic                at_root;
  logic [WordW-1:0]    rdata;
  logic [WordW-1:0]    word;
  logic [IdxW-1:0]     link0, link1;
  logic                key_bit;
  logic [IdxW-1:0]     ins_child;
  logic                ins_brk;
  logic [SumW-1:0]     need_sum;
  logic                fits;
  logic                last_lvl;
  logic [IdxW-1:0]     qry_want, qry_other, qry_next;
  logic                qry_stop;
  logic [KEY_BITS-1:0] ans_d;
  logic [KEY_BITS-1:0] best_max;
  logic [IdxW-1:0]     nf_idx;
  logic [IdxW-1:0]     pos_inc;
  logic [WordW-1:0]    par_word, alloc_word;
  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_addr;
  logic [WordW-1:0]    ram_wdata;

  assign lvl      = LvlW'(r_q - RW'(1));
  assign at_root  = (pos_q == '0);
  // root links live in flip-flops so a set start empties the trie at once
  assign word     = at_root ? {root_one_q, root_zero_q} : rdata;
  assign link0    = word[IdxW-1:0];
  assign link1    = word[WordW-1:IdxW];
  assign key_bit  = key_q[lvl];
  assign ins_child = key_bit ? link1 : link0;
  assign ins_brk  = (ins_child == '0);
  assign need_sum = SumW'(next_free_q) + SumW'(r_q);
  assign fits     = (need_sum <= SumW'(NODE_COUNT));
  assign last_lvl = (r_q == RW'(1));

  assign qry_want  = key_bit ? link0 : link1;
  assign qry_other = key_bit ? link1 : link0;
  assign qry_stop  = (qry_want == '0) && (qry_other == '0);
  assign qry_next  = (qry_want != '0) ? qry_want : qry_other;

  always_comb begin
    ans_d = ans_q;
    if (qry_want != '0) begin
      ans_d[lvl] = 1'b1;
    end
  end

  assign best_max = (ans_q > best_q) ? ans_q : best_q;

  assign nf_idx   = IdxW'(next_free_q);
  assign pos_inc  = pos_q + IdxW'(1);
  assign par_word = key_bit ? {nf_idx, link0} : {link1, nf_idx};

  // every freshly allocated node is written whole, so stale RAM contents never show
  always_comb begin
    if (r_q == '0) begin
      alloc_word = '0;
    end else if (key_bit) begin
      alloc_word = {pos_inc, {IdxW{1'b0}}};
    end else begin
      alloc_word = {{IdxW{1'b0}}, pos_inc};
    end
  end

  assign ram_we    = (cmd_i.ins_walk && ins_brk && fits && !at_root) || cmd_i.ins_alloc;
  assign ram_re    = !ram_we;
  assign ram_wdata = cmd_i.ins_alloc ? alloc_word : par_word;

  always_comb begin
    priority if (cmd_i.ins_alloc || (cmd_i.ins_walk && ins_brk)) begin
      ram_addr = pos_q;
    end else if (cmd_i.ins_walk) begin
      ram_addr = ins_child;
    end else if (cmd_i.qry_walk) begin
      ram_addr = qry_next;
    end else begin
      ram_addr = pos_q;
    end
  end

  btmx_ram #(
    .WIDTH (WordW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      r_q         <= '0;
      full_q      <= 1'b0;
      best_q      <= '0;
      next_free_q <= CntW'(1);
      root_zero_q <= '0;
      root_one_q  <= '0;
    end else begin
      priority if (cmd_i.load) begin
        pos_q  <= '0;
        r_q    <= RW'(KEY_BITS);
        full_q <= 1'b0;
        if (start_of_set_i) begin
          next_free_q <= CntW'(1);
          best_q      <= '0;
          root_zero_q <= '0;
          root_one_q  <= '0;
        end
      end else if (cmd_i.ins_walk) begin
        if (!ins_brk) begin
          if (last_lvl) begin
            pos_q <= '0;
            r_q   <= RW'(KEY_BITS);
          end else begin
            pos_q <= ins_child;
            r_q   <= r_q - RW'(1);
          end
        end else if (fits) begin
          if (at_root) begin
            if (key_bit) root_one_q  <= nf_idx;
            else         root_zero_q <= nf_idx;
          end
          next_free_q <= CntW'(need_sum);
          pos_q       <= nf_idx;
          r_q         <= r_q - RW'(1);
        end else begin
          // drop the insertion, query the trie as it stands
          full_q <= 1'b1;
          pos_q  <= '0;
          r_q    <= RW'(KEY_BITS);
        end
      end else if (cmd_i.ins_alloc) begin
        if (r_q == '0) begin
          pos_q <= '0;
          r_q   <= RW'(KEY_BITS);
        end else begin
          pos_q <= pos_inc;
          r_q   <= r_q - RW'(1);
        end
      end else if (cmd_i.qry_walk) begin
        if (!qry_stop) begin
          pos_q <= qry_next;
          r_q   <= r_q - RW'(1);
        end
      end else if (cmd_i.finish) begin
        best_q <= best_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= KEY_BITS'(key_value_i);
      ans_q <= '0;
    end else if (cmd_i.qry_walk) begin
      ans_q <= ans_d;
    end
  end

  assign sts_o.ins_to_alloc = ins_brk && fits;
  assign sts_o.ins_to_qry   = ins_brk ? !fits : last_lvl;
  assign sts_o.alloc_to_qry = (r_q == '0);
  assign sts_o.qry_end      = last_lvl || qry_stop;

  assign max_xor_o     = FieldW'(ans_q);
  assign best_so_far_o = FieldW'(best_max);
  assign store_full_o  = full_q;

endmodule

FILE: design/binary_trie_max_xor_unit.sv
// Binary trie max-XOR unit: inserts each key into a trie, then finds the largest XOR.
// The next start is taken in the cycle after the result strobe. Node RAM read once per
// trie level. Reset clears root links, fill count and running maximum; the node RAM is not
// swept, each node is written whole when allocated. The receiver cannot stall results.
module binary_trie_max_xor_unit #(
  parameter int unsigned KEY_BITS   = btmx_pkg::KeyBitsDef,
  parameter int unsigned NODE_COUNT = btmx_pkg::NodeCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [btmx_pkg::FieldW-1:0] key_value_i,
  input  logic                        start_of_set_i,
  output logic                        done_o,
  output logic [btmx_pkg::FieldW-1:0] max_xor_o,
  output logic [btmx_pkg::FieldW-1:0] best_so_far_o,
  output logic                        store_full_o
);
  import btmx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  btmx_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  btmx_dp #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .key_value_i    (key_value_i),
    .start_of_set_i (start_of_set_i),
    .max_xor_o      (max_xor_o),
    .best_so_far_o  (best_so_far_o),
    .store_full_o   (store_full_o)
  );

endmodule
